// ===== hw/rtl/itp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the infix to postfix converter: character codes, item classes,
// error codes, queue entry type and the classify and precedence functions.
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_CARET  = 8'h5E;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_CLOSE    = 3'd1;
  localparam logic [2:0] ERR_OPEN     = 3'd2;
  localparam logic [2:0] ERR_BADCHAR  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  typedef logic [2:0] cls_t;
  localparam cls_t CLS_LETTER = 3'd0;
  localparam cls_t CLS_OPEN   = 3'd1;
  localparam cls_t CLS_CLOSE  = 3'd2;
  localparam cls_t CLS_OP     = 3'd3;
  localparam cls_t CLS_BAD    = 3'd4;

  typedef struct packed {
    cls_t       cls;
    logic [1:0] prec;
    logic [7:0] sym;
    logic       last;
  } q_entry_t;

  function automatic logic [1:0] precedence(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CHAR_PLUS || c == CHAR_MINUS) p = 2'd1;
    else if (c == CHAR_STAR || c == CHAR_SLASH) p = 2'd2;
    else if (c == CHAR_CARET) p = 2'd3;
    return p;
  endfunction

  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    if ((c >= CHAR_LOW_A && c <= CHAR_LOW_Z) || (c >= CHAR_UP_A && c <= CHAR_UP_Z)) begin
      k = CLS_LETTER;
    end else if (c == CHAR_LPAREN) begin
      k = CLS_OPEN;
    end else if (c == CHAR_RPAREN) begin
      k = CLS_CLOSE;
    end else if (precedence(c) != 2'd0) begin
      k = CLS_OP;
    end else begin
      k = CLS_BAD;
    end
    return k;
  endfunction

endpackage

// ===== hw/rtl/itp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/itp_front.sv =====
`timescale 1ns / 1ps
// Front end: accept input items, classify each character and hold them in a
// short queue for the back end. Depends on itp_pkg.
module itp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  output logic             q_valid,
  output itp_pkg::q_entry_t q_head,
  input  logic             q_pop
);

  localparam int QD  = itp_pkg::QUEUE_DEPTH;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  itp_pkg::q_entry_t entries [QD];
  logic [QAW-1:0]    wr_ptr;
  logic [QAW-1:0]    rd_ptr;
  logic [QCW-1:0]    fill;
  logic              push;
  itp_pkg::q_entry_t new_entry;

  assign s_tready = (fill != QCW'(QD));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != '0);
  assign q_head   = entries[rd_ptr];

  always_comb begin
    new_entry.cls  = itp_pkg::classify(s_tdata);
    new_entry.prec = itp_pkg::precedence(s_tdata);
    new_entry.sym  = s_tdata;
    new_entry.last = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/itp_back.sv =====
`timescale 1ns / 1ps
// Back end: run the operator stack for the item at the queue head, hold the
// newest result to mark the last one, and drive the output register.
// Depends on itp_pkg and itp_ram.
module itp_back #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  itp_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic [3:0]        m_tuser
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0]    st;
  logic [1:0]    st_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [7:0]    top;
  logic [7:0]    top_next;
  logic [7:0]    below;
  logic          open_seen;
  logic          open_next;

  logic          hold_valid;
  logic [7:0]    hold_sym;
  logic [2:0]    hold_err;

  logic          emit_req;
  logic [7:0]    emit_sym;
  logic [2:0]    emit_err;
  logic          emit_fire;
  logic          push_en;
  logic          pop_en;
  logic          fin_fire;
  logic          out_free;
  logic          emit_ok;
  logic          has;
  logic          full;
  logic          top_open;
  logic          adv_state;

  logic          out_load;
  logic [7:0]    out_sym;
  logic [2:0]    out_err;
  logic          out_run;
  logic          out_done;

  assign out_free = !m_tvalid || m_tready;
  assign emit_ok  = !hold_valid || out_free;
  assign has      = (count != '0);
  assign full     = (count == CW'(STACK_DEPTH));
  assign top_open = (top == itp_pkg::CHAR_LPAREN);

  always_comb begin
    adv_state = q_head.last;
    st_next   = st;
    open_next = open_seen;
    emit_req  = 1'b0;
    emit_sym  = '0;
    emit_err  = itp_pkg::ERR_NONE;
    push_en   = 1'b0;
    pop_en    = 1'b0;
    fin_fire  = 1'b0;
    q_pop     = 1'b0;
    unique case (st)
      S_RUN: begin
        if (q_valid) begin
          case (q_head.cls)
            itp_pkg::CLS_LETTER: begin
              emit_req = 1'b1;
              emit_sym = q_head.sym;
              st_next  = adv_state ? S_FLUSH : S_DONE;
            end
            itp_pkg::CLS_OPEN: begin
              if (full) begin
                emit_req = 1'b1;
                emit_err = itp_pkg::ERR_OVERFLOW;
              end else begin
                push_en = 1'b1;
              end
              st_next = adv_state ? S_FLUSH : S_DONE;
            end
            itp_pkg::CLS_CLOSE: begin
              if (has && !top_open) begin
                emit_req = 1'b1;
                emit_sym = top;
                pop_en   = 1'b1;
              end else if (!has) begin
                emit_req = 1'b1;
                emit_err = itp_pkg::ERR_CLOSE;
                st_next  = adv_state ? S_FLUSH : S_DONE;
              end else begin
                pop_en  = 1'b1;
                st_next = adv_state ? S_FLUSH : S_DONE;
              end
            end
            itp_pkg::CLS_OP: begin
              if (has && !top_open && itp_pkg::precedence(top) >= q_head.prec) begin
                emit_req = 1'b1;
                emit_sym = top;
                pop_en   = 1'b1;
              end else begin
                if (full) begin
                  emit_req = 1'b1;
                  emit_err = itp_pkg::ERR_OVERFLOW;
                end else begin
                  push_en = 1'b1;
                end
                st_next = adv_state ? S_FLUSH : S_DONE;
              end
            end
            default: begin
              emit_req = 1'b1;
              emit_err = itp_pkg::ERR_BADCHAR;
              st_next  = adv_state ? S_FLUSH : S_DONE;
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (has) begin
          pop_en = 1'b1;
          if (top_open) begin
            open_next = 1'b1;
          end else begin
            emit_req = 1'b1;
            emit_sym = top;
          end
        end else begin
          if (open_seen) begin
            emit_req = 1'b1;
            emit_err = itp_pkg::ERR_OPEN;
          end
          open_next = 1'b0;
          st_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (!(hold_valid || q_head.last) || out_free) begin
          fin_fire = 1'b1;
          q_pop    = 1'b1;
          st_next  = S_RUN;
        end
      end
      default: begin
        st_next = S_RUN;
      end
    endcase
    if (emit_req && !emit_ok) begin
      push_en   = 1'b0;
      pop_en    = 1'b0;
      st_next   = st;
      open_next = open_seen;
    end
  end

  assign emit_fire = emit_req && emit_ok;

  always_comb begin
    out_load = 1'b0;
    out_sym  = hold_sym;
    out_err  = hold_err;
    out_run  = 1'b0;
    out_done = 1'b0;
    if (emit_fire && hold_valid) begin
      out_load = 1'b1;
    end else if (fin_fire && hold_valid) begin
      out_load = 1'b1;
      out_run  = 1'b1;
      out_done = q_head.last;
    end else if (fin_fire && q_head.last) begin
      out_load = 1'b1;
      out_sym  = '0;
      out_err  = itp_pkg::ERR_NONE;
      out_run  = 1'b1;
      out_done = 1'b1;
    end
  end

  always_comb begin
    count_next = count;
    top_next   = top;
    if (push_en) begin
      count_next = count + 1'b1;
      top_next   = q_head.sym;
    end else if (pop_en) begin
      count_next = count - 1'b1;
      top_next   = below;
    end
  end

  itp_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (AW'(count)),
    .wr_data (q_head.sym),
    .rd_addr (AW'(count_next - CW'(2))),
    .rd_data (below)
  );

  always_ff @(posedge clk) begin
    top <= top_next;
    if (emit_fire) begin
      hold_sym <= emit_sym;
      hold_err <= emit_err;
    end
    if (out_load) begin
      m_tdata    <= out_sym;
      m_tlast    <= out_run;
      m_tuser    <= {out_err, out_done};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_RUN;
      count      <= '0;
      open_seen  <= 1'b0;
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      st        <= st_next;
      count     <= count_next;
      open_seen <= open_next;
      if (emit_fire) begin
        hold_valid <= 1'b1;
      end else if (fin_fire) begin
        hold_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// Top level of the infix to postfix converter: front end with item queue,
// back end with operator stack. Depends on itp_pkg, itp_front, itp_back.
//
//   channel  | direction | tdata          | tlast      | tuser
//   s_*      | in        | symbol         | expr_last  | -
//   m_*      | out       | out_symbol     | run_last   | expr_done, error_code
//
// Each item is handled in the run state and retired in the done state;
// stack RAM reads allow one pop a cycle while the back end is not held,
// and a final item first passes through the flush state to empty the
// stack. Synchronous reset empties queue, stack and output register. Input
// stalls only while the two-entry queue is full; output stalls hold the back
// end once its held result and output register are both occupied.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_symbol
  output logic       m_tlast,
  output logic [3:0] m_tuser    // [0] expr_done, [3:1] error_code
);

  logic              q_valid;
  itp_pkg::q_entry_t q_head;
  logic              q_pop;

  itp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== hw/rtl/itp_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the infix to postfix converter, bound to the top level.
// Depends on itp_pkg.
module itp_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [3:0] m_tuser
);

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("expression end without run end");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3:1] != itp_pkg::ERR_NONE |-> m_tdata == 8'd0)
    else $error("error item carries a symbol");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata == 8'd0 && m_tuser[3:1] == itp_pkg::ERR_NONE |-> m_tuser[0])
    else $error("empty item outside expression end");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
